// File: rtl/btc_pkg.sv
package btc_pkg;

    // Port field widths
    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int IDX_W    = 3;
    localparam int TEMP_O_W = 15;
    localparam int PRES_O_W = 17;

    // Internal datapath widths, sized to the worst case of every field
    localparam int DT_W      = 26;
    localparam int PROD_W    = 43;
    localparam int DT2_W     = 48;
    localparam int TQ_W      = 18;
    localparam int OFFQ_W    = 35;
    localparam int SENSQ_W   = 34;
    localparam int TEMP_W    = 19;
    localparam int TEMPF_W   = 20;
    localparam int T2_W      = 17;
    localparam int OFF_W     = 41;
    localparam int SENS_W    = 39;
    localparam int SQA_W     = 34;
    localparam int SQB_W     = 36;
    localparam int SENS_LO_W = 20;
    localparam int SENS_HI_W = SENS_W - SENS_LO_W;
    localparam int PP_LO_W   = RAW_W + SENS_LO_W;
    localparam int PP_HI_W   = RAW_W + 1 + SENS_HI_W - 1;
    localparam int PSUM_W    = 64;
    localparam int Q_W       = 43;
    localparam int PQ_W      = 28;

    // Scaling shifts
    localparam int C5_SHIFT     = 8;
    localparam int TEMP_SHIFT   = 23;
    localparam int OFF_C_SHIFT  = 17;
    localparam int OFF_T_SHIFT  = 6;
    localparam int SENS_C_SHIFT = 16;
    localparam int SENS_T_SHIFT = 7;
    localparam int T2_SHIFT     = 31;
    localparam int OFF2_SHIFT   = 4;
    localparam int P1_SHIFT     = 21;
    localparam int P2_SHIFT     = 15;

    // Correction coefficients and limits
    localparam int OFF2_COLD_K   = 61;
    localparam int OFF2_VCOLD_K  = 15;
    localparam int SENS2_COLD_K  = 2;
    localparam int SENS2_VCOLD_K = 8;
    localparam int TEMP_REF      = 2000;
    localparam int TEMP_VCOLD    = -1500;
    localparam int TEMP_MIN      = -4000;
    localparam int TEMP_MAX      = 8500;
    localparam int PRES_MAX      = 131071;

    // Calibration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    typedef struct packed {
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;
    } t_raw;

    // First-order results and the terms the cold correction needs
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [TQ_W-1:0]   a;
        logic signed [TEMP_W-1:0] b;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [T2_W-1:0]          t2;
        logic                     cold;
        logic                     vcold;
    } t_fo;

    // Corrected temperature, offset and sensitivity
    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [TEMPF_W-1:0] temp;
        logic signed [OFF_W-1:0]   off;
        logic signed [SENS_W-1:0]  sens;
    } t_so;

    typedef struct packed {
        logic signed [TEMP_O_W-1:0] temperature_centi;
        logic [PRES_O_W-1:0]        pressure_centi;
    } t_res;

endpackage

// File: rtl/btc_in_if.sv
interface btc_in_if;
    import btc_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);

endinterface

// File: rtl/btc_out_if.sv
interface btc_out_if;
    import btc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [TEMP_O_W-1:0] temperature_centi;
    logic [PRES_O_W-1:0]        pressure_centi;

    modport source (output valid, output temperature_centi, output pressure_centi,
                    input ready);
    modport sink   (input valid, input temperature_centi, input pressure_centi,
                    output ready);

endinterface

// File: rtl/btc_cfg_if.sv
interface btc_cfg_if;
    import btc_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CAL_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// File: rtl/btc_cfg_regs.sv
module btc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_vld,
    input  logic [btc_pkg::IDX_W-1:0]   i_wr_idx,
    input  logic [btc_pkg::CAL_W-1:0]   i_wr_data,
    output logic                        o_wr_rdy,
    output btc_pkg::t_cal               o_cal
);
    import btc_pkg::*;

    t_cal r_cal;

    assign o_wr_rdy = 1'b1;
    assign o_cal    = r_cal;

    // Store the calibration word; drop writes beyond the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_wr_vld) begin
            case (i_wr_idx)
                CFG_C1:  r_cal.c1 <= i_wr_data;
                CFG_C2:  r_cal.c2 <= i_wr_data;
                CFG_C3:  r_cal.c3 <= i_wr_data;
                CFG_C4:  r_cal.c4 <= i_wr_data;
                CFG_C5:  r_cal.c5 <= i_wr_data;
                CFG_C6:  r_cal.c6 <= i_wr_data;
                default: r_cal    <= r_cal;
            endcase
        end
    end

endmodule

// File: rtl/btc_first_order.sv
module btc_first_order (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  btc_pkg::t_cal i_cal,
    input  logic          i_vld,
    input  btc_pkg::t_raw i_raw,
    output logic          o_rdy,
    output logic          o_vld,
    output btc_pkg::t_fo  o_fo,
    input  logic          i_rdy
);
    import btc_pkg::*;

    logic rdy1, rdy2, rdy3;
    logic r_vld1, r_vld2, r_vld3;

    // Stage 1: temperature difference
    logic [RAW_W-1:0]       r_d1_1;
    logic signed [DT_W-1:0] r_dt1;
    logic signed [DT_W-1:0] n_dt;

    // Stage 2: products with dT
    logic [RAW_W-1:0]         r_d1_2;
    logic signed [PROD_W-1:0] r_p_t, r_p_off, r_p_sens;
    logic [DT2_W-1:0]         r_p_dt2;
    logic signed [PROD_W-1:0] n_p_t, n_p_off, n_p_sens;
    logic signed [DT2_W:0]    n_p_dt2;

    // Stage 3: scaled first-order terms
    t_fo                       r_fo;
    t_fo                       n_fo;
    logic signed [PROD_W-1:0]  adj_t, adj_off, adj_sens;
    logic signed [TQ_W-1:0]    tq;
    logic signed [OFFQ_W-1:0]  offq;
    logic signed [SENSQ_W-1:0] sensq;

    assign rdy3  = !r_vld3 || i_rdy;
    assign rdy2  = !r_vld2 || rdy3;
    assign rdy1  = !r_vld1 || rdy2;
    assign o_rdy = rdy1;
    assign o_vld = r_vld3;
    assign o_fo  = r_fo;

    assign n_dt = $signed({2'b00, i_raw.d2}) - $signed({2'b00, i_cal.c5, 8'h00});

    assign n_p_t    = r_dt1 * $signed({1'b0, i_cal.c6});
    assign n_p_off  = r_dt1 * $signed({1'b0, i_cal.c4});
    assign n_p_sens = r_dt1 * $signed({1'b0, i_cal.c3});
    assign n_p_dt2  = r_dt1 * r_dt1;

    // Truncate toward zero: bias negative values before the arithmetic shift
    always_comb begin
        adj_t    = r_p_t + (r_p_t[PROD_W-1] ?
                            PROD_W'((64'd1 << TEMP_SHIFT) - 64'd1) : '0);
        adj_off  = r_p_off + (r_p_off[PROD_W-1] ?
                              PROD_W'((64'd1 << OFF_T_SHIFT) - 64'd1) : '0);
        adj_sens = r_p_sens + (r_p_sens[PROD_W-1] ?
                               PROD_W'((64'd1 << SENS_T_SHIFT) - 64'd1) : '0);
        tq    = adj_t[TEMP_SHIFT+TQ_W-1:TEMP_SHIFT];
        offq  = adj_off[OFF_T_SHIFT+OFFQ_W-1:OFF_T_SHIFT];
        sensq = adj_sens[SENS_T_SHIFT+SENSQ_W-1:SENS_T_SHIFT];

        n_fo.d1    = r_d1_2;
        n_fo.a     = tq;
        n_fo.temp  = TEMP_W'(tq) + TEMP_W'(TEMP_REF);
        n_fo.b     = TEMP_W'(tq) + TEMP_W'(TEMP_REF - TEMP_VCOLD);
        n_fo.off   = $signed(OFF_W'(i_cal.c2) << OFF_C_SHIFT) + OFF_W'(offq);
        n_fo.sens  = $signed(SENS_W'(i_cal.c1) << SENS_C_SHIFT) + SENS_W'(sensq);
        n_fo.t2    = r_p_dt2[T2_SHIFT+T2_W-1:T2_SHIFT];
        n_fo.cold  = tq[TQ_W-1];
        n_fo.vcold = n_fo.b[TEMP_W-1];
    end

    // Advance valid bits wherever the next stage is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_vld;
            if (rdy2) r_vld2 <= r_vld1;
            if (rdy3) r_vld3 <= r_vld2;
        end
    end

    // Load payload only with a valid beat
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_vld) begin
            r_d1_1 <= i_raw.d1;
            r_dt1  <= n_dt;
        end
        if (rdy2 && r_vld1) begin
            r_d1_2   <= r_d1_1;
            r_p_t    <= n_p_t;
            r_p_off  <= n_p_off;
            r_p_sens <= n_p_sens;
            r_p_dt2  <= n_p_dt2[DT2_W-1:0];
        end
        if (rdy3 && r_vld2) begin
            r_fo <= n_fo;
        end
    end

endmodule

// File: rtl/btc_second_order.sv
module btc_second_order (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  btc_pkg::t_fo i_fo,
    output logic         o_rdy,
    output logic         o_vld,
    output btc_pkg::t_so o_so,
    input  logic         i_rdy
);
    import btc_pkg::*;

    logic rdy4, rdy5, rdy6;
    logic r_vld4, r_vld5, r_vld6;

    // Stage 4: squares of the cold distances
    t_fo                          r_fo4;
    logic [SQA_W-1:0]             r_sq_a;
    logic [SQB_W-1:0]             r_sq_b;
    logic signed [2*TQ_W-1:0]     n_sq_a;
    logic signed [2*TEMP_W-1:0]   n_sq_b;

    // Stage 5: correction terms and corrected temperature
    logic [RAW_W-1:0]          r_d1_5;
    logic signed [TEMPF_W-1:0] r_temp5;
    logic signed [OFF_W-1:0]   r_off5;
    logic signed [SENS_W-1:0]  r_sens5;
    logic [OFF_W-1:0]          r_off2;
    logic [SENS_W-1:0]         r_sens2;
    logic [OFF_W-1:0]          n_off2;
    logic [SENS_W-1:0]         n_sens2;
    logic signed [TEMPF_W-1:0] n_temp5;

    // Stage 6: apply the corrections
    t_so r_so;
    t_so n_so;

    assign rdy6  = !r_vld6 || i_rdy;
    assign rdy5  = !r_vld5 || rdy6;
    assign rdy4  = !r_vld4 || rdy5;
    assign o_rdy = rdy4;
    assign o_vld = r_vld6;
    assign o_so  = r_so;

    assign n_sq_a = i_fo.a * i_fo.a;
    assign n_sq_b = i_fo.b * i_fo.b;

    // Build OFF2 and SENS2, zero above the cold threshold
    always_comb begin
        n_off2  = '0;
        n_sens2 = '0;
        n_temp5 = TEMPF_W'(r_fo4.temp);
        if (r_fo4.cold) begin
            n_off2  = (OFF_W'(r_sq_a) * OFF_W'(OFF2_COLD_K)) >> OFF2_SHIFT;
            n_sens2 = SENS_W'(r_sq_a) * SENS_W'(SENS2_COLD_K);
            n_temp5 = TEMPF_W'(r_fo4.temp) - $signed({3'b000, r_fo4.t2});
            if (r_fo4.vcold) begin
                n_off2  = n_off2 + OFF_W'(r_sq_b) * OFF_W'(OFF2_VCOLD_K);
                n_sens2 = n_sens2 + SENS_W'(r_sq_b) * SENS_W'(SENS2_VCOLD_K);
            end
        end
    end

    always_comb begin
        n_so.d1   = r_d1_5;
        n_so.temp = r_temp5;
        n_so.off  = r_off5 - $signed(r_off2);
        n_so.sens = r_sens5 - $signed(r_sens2);
    end

    // Advance valid bits wherever the next stage is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else begin
            if (rdy4) r_vld4 <= i_vld;
            if (rdy5) r_vld5 <= r_vld4;
            if (rdy6) r_vld6 <= r_vld5;
        end
    end

    // Load payload only with a valid beat
    always_ff @(posedge i_clk) begin
        if (rdy4 && i_vld) begin
            r_fo4  <= i_fo;
            r_sq_a <= n_sq_a[SQA_W-1:0];
            r_sq_b <= n_sq_b[SQB_W-1:0];
        end
        if (rdy5 && r_vld4) begin
            r_d1_5  <= r_fo4.d1;
            r_temp5 <= n_temp5;
            r_off5  <= r_fo4.off;
            r_sens5 <= r_fo4.sens;
            r_off2  <= n_off2;
            r_sens2 <= n_sens2;
        end
        if (rdy6 && r_vld5) begin
            r_so <= n_so;
        end
    end

endmodule

// File: rtl/btc_pressure.sv
module btc_pressure (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  btc_pkg::t_so  i_so,
    output logic          o_rdy,
    output logic          o_vld,
    output btc_pkg::t_res o_res,
    input  logic          i_rdy
);
    import btc_pkg::*;

    logic rdy7, rdy8, rdy9, rdy10;
    logic r_vld7, r_vld8, r_vld9, r_vld10;

    // Stage 7: D1 x SENS as two partial products
    logic [PP_LO_W-1:0]         r_pp_lo;
    logic signed [PP_HI_W-1:0]  r_pp_hi;
    logic signed [TEMPF_W-1:0]  r_temp7;
    logic signed [OFF_W-1:0]    r_off7;
    logic [PP_LO_W-1:0]         n_pp_lo;
    logic signed [PP_HI_W-1:0]  n_pp_hi;

    // Stage 8: recombine the product
    logic signed [PSUM_W-1:0]   r_prod;
    logic signed [TEMPF_W-1:0]  r_temp8;
    logic signed [OFF_W-1:0]    r_off8;
    logic signed [PSUM_W-1:0]   n_prod;

    // Stage 9: scale and take off the offset
    logic signed [Q_W-1:0]      r_q;
    logic signed [TEMPF_W-1:0]  r_temp9;
    logic signed [PSUM_W-1:0]   adj_prod;
    logic signed [Q_W-1:0]      n_q;

    // Stage 10: final scale and saturation
    t_res                       r_res;
    t_res                       n_res;
    logic signed [Q_W-1:0]      adj_q;
    logic signed [PQ_W-1:0]     pq;

    assign rdy10 = !r_vld10 || i_rdy;
    assign rdy9  = !r_vld9 || rdy10;
    assign rdy8  = !r_vld8 || rdy9;
    assign rdy7  = !r_vld7 || rdy8;
    assign o_rdy = rdy7;
    assign o_vld = r_vld10;
    assign o_res = r_res;

    assign n_pp_lo = PP_LO_W'(i_so.d1) * PP_LO_W'(i_so.sens[SENS_LO_W-1:0]);
    assign n_pp_hi = $signed({1'b0, i_so.d1}) * $signed(i_so.sens[SENS_W-1:SENS_LO_W]);

    assign n_prod = (PSUM_W'(r_pp_hi) <<< SENS_LO_W) + $signed(PSUM_W'(r_pp_lo));

    // Truncate toward zero, then subtract the offset
    always_comb begin
        adj_prod = r_prod + (r_prod[PSUM_W-1] ?
                             PSUM_W'((64'd1 << P1_SHIFT) - 64'd1) : '0);
        n_q = adj_prod[P1_SHIFT+Q_W-1:P1_SHIFT] - Q_W'(r_off8);
    end

    // Truncate toward zero, then clamp both results
    always_comb begin
        adj_q = r_q + (r_q[Q_W-1] ? Q_W'((64'd1 << P2_SHIFT) - 64'd1) : '0);
        pq    = adj_q[P2_SHIFT+PQ_W-1:P2_SHIFT];
        if (pq[PQ_W-1]) begin
            n_res.pressure_centi = '0;
        end else if (pq > PQ_W'(PRES_MAX)) begin
            n_res.pressure_centi = PRES_O_W'(PRES_MAX);
        end else begin
            n_res.pressure_centi = pq[PRES_O_W-1:0];
        end
        if (r_temp9 < TEMPF_W'(TEMP_MIN)) begin
            n_res.temperature_centi = TEMP_O_W'(TEMP_MIN);
        end else if (r_temp9 > TEMPF_W'(TEMP_MAX)) begin
            n_res.temperature_centi = TEMP_O_W'(TEMP_MAX);
        end else begin
            n_res.temperature_centi = r_temp9[TEMP_O_W-1:0];
        end
    end

    // Advance valid bits wherever the next stage is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld7  <= 1'b0;
            r_vld8  <= 1'b0;
            r_vld9  <= 1'b0;
            r_vld10 <= 1'b0;
        end else begin
            if (rdy7)  r_vld7  <= i_vld;
            if (rdy8)  r_vld8  <= r_vld7;
            if (rdy9)  r_vld9  <= r_vld8;
            if (rdy10) r_vld10 <= r_vld9;
        end
    end

    // Load payload only with a valid beat
    always_ff @(posedge i_clk) begin
        if (rdy7 && i_vld) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
            r_temp7 <= i_so.temp;
            r_off7  <= i_so.off;
        end
        if (rdy8 && r_vld7) begin
            r_prod  <= n_prod;
            r_temp8 <= r_temp7;
            r_off8  <= r_off7;
        end
        if (rdy9 && r_vld8) begin
            r_q     <= n_q;
            r_temp9 <= r_temp8;
        end
        if (rdy10 && r_vld9) begin
            r_res <= n_res;
        end
    end

endmodule

// File: rtl/barometer_temperature_compensation.sv
// Second-order barometer compensation: each beat carries one raw pressure and one raw
// temperature conversion, and each returns one beat with temperature and pressure in
// hundredths, saturated to [-4000, 8500] and [0, 131071]. The six calibration words are
// written through the configuration channel (always ready; indexes above five are
// ignored); the user must write them only while no item is in flight, as the block does not
// enforce it. The datapath is a ten-stage register pipeline that takes one pair per cycle
// while the output is not held; the depth is set by the chain of multiplies, the longest
// being the 24 x 39 bit pressure product split over two stages. A held output stalls only
// the stages behind it, so empty stages still take new beats.
module barometer_temperature_compensation (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btc_in_if.sink     i_in,
    btc_cfg_if.sink    i_cfg,
    btc_out_if.source  o_out
);
    import btc_pkg::*;

    t_cal cal;
    t_raw raw;
    t_fo  fo;
    t_so  so;
    t_res res;
    logic fo_vld, fo_rdy;
    logic so_vld, so_rdy;

    assign raw.d1 = i_in.raw_pressure;
    assign raw.d2 = i_in.raw_temperature;

    btc_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_vld  (i_cfg.valid),
        .i_wr_idx  (i_cfg.index),
        .i_wr_data (i_cfg.data),
        .o_wr_rdy  (i_cfg.ready),
        .o_cal     (cal)
    );

    btc_first_order u_first_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (cal),
        .i_vld   (i_in.valid),
        .i_raw   (raw),
        .o_rdy   (i_in.ready),
        .o_vld   (fo_vld),
        .o_fo    (fo),
        .i_rdy   (fo_rdy)
    );

    btc_second_order u_second_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fo_vld),
        .i_fo    (fo),
        .o_rdy   (fo_rdy),
        .o_vld   (so_vld),
        .o_so    (so),
        .i_rdy   (so_rdy)
    );

    btc_pressure u_pressure (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (so_vld),
        .i_so    (so),
        .o_rdy   (so_rdy),
        .o_vld   (o_out.valid),
        .o_res   (res),
        .i_rdy   (o_out.ready)
    );

    assign o_out.temperature_centi = res.temperature_centi;
    assign o_out.pressure_centi    = res.pressure_centi;

`ifndef SYNTHESIS
    // An empty output stage must leave the whole pipeline open for a new beat
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with the output stage empty");

    // Temperature leaves the clamp within its range
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($signed(o_out.temperature_centi) >= TEMP_O_W'(TEMP_MIN) &&
                         $signed(o_out.temperature_centi) <= TEMP_O_W'(TEMP_MAX)))
        else $error("temperature beat outside saturation range");

    // A stalled output beat must stay valid while the whole pipeline is full
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready && !i_in.ready) |=> o_out.valid)
        else $error("output beat lost while pipeline full");
`endif

endmodule
